@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ARPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ARPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/arpe_pkg.sv @@
// ----------------------------------------------------------------------------
// arpe_pkg
// types, constants and codes of the arp / icmp echo responder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arpe_pkg;

  localparam int MAX_FRAME_DEF = 256;
  localparam int HDR_LEN       = 42;
  localparam int MIN_TOT       = 28;
  localparam int ETH_HDR_LEN   = 14;
  localparam int ICMP_OFF      = 34;
  localparam int ICMP_CSUM_OFF = 36;

  localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ARP_HTYPE_ETH = 16'h0001;
  localparam logic [7:0]  ARP_HLEN      = 8'd6;
  localparam logic [7:0]  ARP_PLEN      = 8'd4;
  localparam logic [15:0] ARP_OP_REPLY  = 16'h0002;
  localparam logic [7:0]  IP_PROTO_ICMP = 8'd1;
  localparam logic [7:0]  ICMP_ECHO_REQ = 8'd8;
  localparam logic [7:0]  ICMP_ECHO_REP = 8'd0;
  localparam logic [15:0] CSUM_MASK     = 16'hffff;

  localparam int   CFG_AW         = 4;
  localparam int   CFG_DW         = 64;
  localparam int   CFG_SEL_BIT    = 3;
  localparam logic CFG_REG_OWN_IP = 1'b0;
  localparam logic CFG_REG_MAC    = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_NONE,
    VERDICT_ARP,
    VERDICT_ICMP,
    VERDICT_DROP
  } verdict_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PULL,
    ST_HREAD,
    ST_HLAST,
    ST_DECIDE,
    ST_SUM,
    ST_SLAST,
    ST_FOLD,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic     rx_acc;
    logic     pull_rd;
    logic     pull_emit;
    logic     emit;
    verdict_t verdict;
    logic     idx_clr;
    logic     idx_icmp;
    logic     idx_inc;
    logic     rd_idx;
    logic     capture;
    logic     sum_add;
    logic     load_arp;
    logic     load_icmp;
    logic     wr_shift;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic pull_ok;
    logic skip_eff;
    logic bad_len;
    logic is_arp;
    logic is_icmp;
    logic icmp_bad;
    logic hdr_end;
    logic sum_end;
  } sts_t;

endpackage

@@ src/arpe_ctrl.sv @@
// ----------------------------------------------------------------------------
// arpe_ctrl
// sequencer for receive, verdict, checksum, reply build and readout
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arpe_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            in_op,
  input  logic            in_rx_last,
  input  arpe_pkg::sts_t  sts,
  output arpe_pkg::cmd_t  cmd,
  output logic            busy
);

  arpe_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arpe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      arpe_pkg::ST_IDLE: begin
        if (start) begin
          if (in_op) begin
            if (sts.pull_ok) state_nxt = arpe_pkg::ST_PULL;
          end else if (in_rx_last && !sts.skip_eff && !sts.bad_len) begin
            state_nxt = arpe_pkg::ST_HREAD;
          end
        end
      end
      arpe_pkg::ST_PULL:  state_nxt = arpe_pkg::ST_IDLE;
      arpe_pkg::ST_HREAD: begin
        if (sts.hdr_end) state_nxt = arpe_pkg::ST_HLAST;
      end
      arpe_pkg::ST_HLAST: state_nxt = arpe_pkg::ST_DECIDE;
      arpe_pkg::ST_DECIDE: begin
        if (sts.is_arp) state_nxt = arpe_pkg::ST_WRITE;
        else if (sts.is_icmp && !sts.icmp_bad) state_nxt = arpe_pkg::ST_SUM;
        else state_nxt = arpe_pkg::ST_IDLE;
      end
      arpe_pkg::ST_SUM: begin
        if (sts.sum_end) state_nxt = arpe_pkg::ST_SLAST;
      end
      arpe_pkg::ST_SLAST: state_nxt = arpe_pkg::ST_FOLD;
      arpe_pkg::ST_FOLD:  state_nxt = arpe_pkg::ST_WRITE;
      arpe_pkg::ST_WRITE: begin
        if (sts.hdr_end) state_nxt = arpe_pkg::ST_IDLE;
      end
      default: state_nxt = arpe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.verdict = arpe_pkg::VERDICT_NONE;
    busy = (state_r != arpe_pkg::ST_IDLE);
    case (state_r)
      arpe_pkg::ST_IDLE: begin
        if (start) begin
          if (in_op) begin
            if (sts.pull_ok) cmd.pull_rd = 1'b1;
            else cmd.emit = 1'b1;
          end else begin
            cmd.rx_acc = 1'b1;
            if (!in_rx_last || sts.skip_eff) begin
              cmd.emit = 1'b1;
            end else if (sts.bad_len) begin
              cmd.emit    = 1'b1;
              cmd.verdict = arpe_pkg::VERDICT_DROP;
            end else begin
              cmd.idx_clr = 1'b1;
            end
          end
        end
      end
      arpe_pkg::ST_PULL: cmd.pull_emit = 1'b1;
      arpe_pkg::ST_HREAD: begin
        cmd.rd_idx  = 1'b1;
        cmd.idx_inc = 1'b1;
        cmd.capture = 1'b1;
      end
      arpe_pkg::ST_HLAST: cmd.capture = 1'b1;
      arpe_pkg::ST_DECIDE: begin
        if (sts.is_arp) begin
          cmd.load_arp = 1'b1;
          cmd.idx_clr  = 1'b1;
        end else if (sts.is_icmp && !sts.icmp_bad) begin
          cmd.idx_icmp = 1'b1;
        end else begin
          cmd.emit    = 1'b1;
          cmd.verdict = sts.is_icmp ? arpe_pkg::VERDICT_DROP : arpe_pkg::VERDICT_NONE;
        end
      end
      arpe_pkg::ST_SUM: begin
        cmd.rd_idx  = 1'b1;
        cmd.idx_inc = 1'b1;
        cmd.sum_add = 1'b1;
      end
      arpe_pkg::ST_SLAST: cmd.sum_add = 1'b1;
      arpe_pkg::ST_FOLD: begin
        cmd.load_icmp = 1'b1;
        cmd.idx_clr   = 1'b1;
      end
      arpe_pkg::ST_WRITE: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (sts.hdr_end) cmd.commit = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

@@ src/arpe_dp.sv @@
// ----------------------------------------------------------------------------
// arpe_dp
// frame store, header shift line, checksum accumulator and result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arpe_dp #(
  parameter int MAX_FRAME = arpe_pkg::MAX_FRAME_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  arpe_pkg::cmd_t  cmd,
  output arpe_pkg::sts_t  sts,
  input  logic [7:0]      in_rx_byte,
  input  logic            in_rx_last,
  input  logic [31:0]     own_ip,
  input  logic [47:0]     station_mac,
  output logic            out_strobe,
  output logic [7:0]      out_tx_byte,
  output logic            out_tx_valid,
  output logic            out_tx_last,
  output logic [1:0]      out_verdict,
  output logic [8:0]      out_reply_length
);

  localparam int AW = $clog2(MAX_FRAME);
  localparam int LW = $clog2(MAX_FRAME + 2);
  localparam int HL = arpe_pkg::HDR_LEN;

  logic [7:0] mem [MAX_FRAME];

  logic [LW-1:0]      cnt_r, n_r, plen_r, pos_r, idx_r, tag_r;
  logic               skip_r, rvalid_r;
  logic [7:0]         rdata_r;
  logic [31:0]        sum_r;
  logic [7:0]         hdr_r [HL];
  arpe_pkg::verdict_t kind_r, pend_r;

  logic               strobe_r, tx_valid_r, tx_last_r;
  logic [7:0]         tx_byte_r;
  arpe_pkg::verdict_t verdict_r;
  logic [8:0]         rlen_r;

  logic [LW-1:0] cnt_nxt, pos_nxt;
  logic          pending, skip_eff, we, re, pull_last;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, sum_byte;
  logic [15:0]   tot;
  logic [16:0]   len17, fold1, fold2;
  logic [15:0]   csum;
  logic [7:0]    mac_b [6];

  assign pending  = (pend_r != arpe_pkg::VERDICT_NONE);
  assign skip_eff = skip_r | pending;
  assign cnt_nxt  = (cnt_r <= LW'(MAX_FRAME)) ? cnt_r + LW'(1) : cnt_r;
  assign pos_nxt  = pos_r + LW'(1);
  assign pull_last = (pos_nxt >= plen_r);
  assign tot      = {hdr_r[16], hdr_r[17]};
  assign len17    = {1'b0, tot} + 17'(arpe_pkg::ETH_HDR_LEN);

  always_comb begin
    for (int k = 0; k < 6; k++) mac_b[k] = station_mac[47-8*k -: 8];
  end

  always_comb begin
    sts.skip_eff = skip_eff;
    sts.bad_len  = (cnt_nxt > LW'(MAX_FRAME)) || (cnt_nxt < LW'(HL));
    sts.pull_ok  = pending && (pos_r < plen_r);
    sts.is_arp   = ({hdr_r[12], hdr_r[13]} == arpe_pkg::ETH_TYPE_ARP)
                && ({hdr_r[38], hdr_r[39], hdr_r[40], hdr_r[41]} == own_ip);
    sts.is_icmp  = ({hdr_r[12], hdr_r[13]} == arpe_pkg::ETH_TYPE_IPV4)
                && ({hdr_r[30], hdr_r[31], hdr_r[32], hdr_r[33]} == own_ip)
                && (hdr_r[23] == arpe_pkg::IP_PROTO_ICMP)
                && (hdr_r[arpe_pkg::ICMP_OFF] == arpe_pkg::ICMP_ECHO_REQ);
    sts.icmp_bad = (tot < 16'(arpe_pkg::MIN_TOT)) || (len17 > 17'(n_r));
    sts.hdr_end  = (idx_r == LW'(HL - 1));
    sts.sum_end  = (idx_r == plen_r - LW'(1));
  end

  // checksum fold
  always_comb begin
    fold1 = {1'b0, sum_r[15:0]} + {1'b0, sum_r[31:16]};
    fold2 = {1'b0, fold1[15:0]} + {16'b0, fold1[16]};
    csum  = ~fold2[15:0] & arpe_pkg::CSUM_MASK;
  end

  // icmp type and checksum bytes count as zero
  always_comb begin
    if (tag_r == LW'(arpe_pkg::ICMP_OFF) || tag_r == LW'(arpe_pkg::ICMP_CSUM_OFF)
        || tag_r == LW'(arpe_pkg::ICMP_CSUM_OFF + 1)) begin
      sum_byte = 8'd0;
    end else begin
      sum_byte = rdata_r;
    end
  end

  // single store port
  always_comb begin
    we    = cmd.wr_shift || (cmd.rx_acc && !skip_eff && (cnt_r < LW'(MAX_FRAME)));
    waddr = cmd.wr_shift ? idx_r[AW-1:0] : cnt_r[AW-1:0];
    wdata = cmd.wr_shift ? hdr_r[0] : in_rx_byte;
    re    = cmd.rd_idx | cmd.pull_rd;
    raddr = cmd.pull_rd ? pos_r[AW-1:0] : idx_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if ((cmd.capture && rvalid_r) || cmd.wr_shift) begin
      for (int k = 0; k < HL - 1; k++) hdr_r[k] <= hdr_r[k+1];
      hdr_r[HL-1] <= rdata_r;
    end else if (cmd.load_arp) begin
      for (int k = 0; k < 6; k++) begin
        hdr_r[k]    <= hdr_r[k+6];
        hdr_r[k+6]  <= mac_b[k];
        hdr_r[k+22] <= mac_b[k];
        hdr_r[k+32] <= hdr_r[k+22];
      end
      for (int k = 0; k < 4; k++) begin
        hdr_r[k+28] <= hdr_r[k+38];
        hdr_r[k+38] <= hdr_r[k+28];
      end
      hdr_r[12] <= arpe_pkg::ETH_TYPE_ARP[15:8];
      hdr_r[13] <= arpe_pkg::ETH_TYPE_ARP[7:0];
      hdr_r[14] <= arpe_pkg::ARP_HTYPE_ETH[15:8];
      hdr_r[15] <= arpe_pkg::ARP_HTYPE_ETH[7:0];
      hdr_r[16] <= arpe_pkg::ETH_TYPE_IPV4[15:8];
      hdr_r[17] <= arpe_pkg::ETH_TYPE_IPV4[7:0];
      hdr_r[18] <= arpe_pkg::ARP_HLEN;
      hdr_r[19] <= arpe_pkg::ARP_PLEN;
      hdr_r[20] <= arpe_pkg::ARP_OP_REPLY[15:8];
      hdr_r[21] <= arpe_pkg::ARP_OP_REPLY[7:0];
    end else if (cmd.load_icmp) begin
      for (int k = 0; k < 6; k++) begin
        hdr_r[k]   <= hdr_r[k+6];
        hdr_r[k+6] <= mac_b[k];
      end
      for (int k = 0; k < 4; k++) begin
        hdr_r[k+26] <= hdr_r[k+30];
        hdr_r[k+30] <= hdr_r[k+26];
      end
      hdr_r[arpe_pkg::ICMP_OFF]        <= arpe_pkg::ICMP_ECHO_REP;
      hdr_r[arpe_pkg::ICMP_CSUM_OFF]   <= csum[15:8];
      hdr_r[arpe_pkg::ICMP_CSUM_OFF+1] <= csum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_idx) tag_r <= idx_r;
    if (cmd.rx_acc && in_rx_last) n_r <= cnt_nxt;
    if (cmd.load_arp) kind_r <= arpe_pkg::VERDICT_ARP;
    else if (cmd.idx_icmp) kind_r <= arpe_pkg::VERDICT_ICMP;
    if (cmd.idx_icmp) sum_r <= '0;
    else if (cmd.sum_add && rvalid_r) begin
      sum_r <= sum_r + (tag_r[0] ? {24'd0, sum_byte} : {16'd0, sum_byte, 8'd0});
    end
    if (cmd.idx_clr) idx_r <= '0;
    else if (cmd.idx_icmp) idx_r <= LW'(arpe_pkg::ICMP_OFF);
    else if (cmd.idx_inc) idx_r <= idx_r + LW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      skip_r   <= 1'b0;
      pend_r   <= arpe_pkg::VERDICT_NONE;
      plen_r   <= '0;
      pos_r    <= '0;
      rvalid_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      rvalid_r <= re;
      strobe_r <= cmd.emit | cmd.pull_emit | cmd.commit;
      if (cmd.rx_acc) begin
        cnt_r  <= in_rx_last ? '0 : cnt_nxt;
        skip_r <= in_rx_last ? 1'b0 : skip_eff;
      end
      if (cmd.load_arp) plen_r <= LW'(HL);
      else if (cmd.idx_icmp) plen_r <= len17[LW-1:0];
      if (cmd.commit) begin
        pend_r <= kind_r;
        pos_r  <= '0;
      end else if (cmd.pull_emit) begin
        if (pull_last) begin
          pend_r <= arpe_pkg::VERDICT_NONE;
          plen_r <= '0;
          pos_r  <= '0;
        end else begin
          pos_r <= pos_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pull_emit) begin
      tx_byte_r  <= rdata_r;
      tx_valid_r <= 1'b1;
      tx_last_r  <= pull_last;
      verdict_r  <= arpe_pkg::VERDICT_NONE;
      rlen_r     <= pull_last ? 9'd0 : 9'(plen_r);
    end else if (cmd.commit) begin
      tx_byte_r  <= 8'd0;
      tx_valid_r <= 1'b0;
      tx_last_r  <= 1'b0;
      verdict_r  <= kind_r;
      rlen_r     <= 9'(plen_r);
    end else if (cmd.emit) begin
      tx_byte_r  <= 8'd0;
      tx_valid_r <= 1'b0;
      tx_last_r  <= 1'b0;
      verdict_r  <= cmd.verdict;
      rlen_r     <= pending ? 9'(plen_r) : 9'd0;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_tx_byte      = tx_byte_r;
  assign out_tx_valid     = tx_valid_r;
  assign out_tx_last      = tx_last_r;
  assign out_verdict      = verdict_r;
  assign out_reply_length = rlen_r;

endmodule

@@ src/arp_icmp_echo_responder.sv @@
// ----------------------------------------------------------------------------
// arp_icmp_echo_responder
// answers arp requests and icmp echo requests for one configured address
// ----------------------------------------------------------------------------
// The result beat of a received byte follows in the next cycle, except for the
// last byte of a frame that passes the length checks. A pull of a pending reply
// byte keeps busy high while the byte is read from the frame store, which has a
// single port with a registered read; a pull with nothing pending does not. The
// last byte of a frame that passes the length checks keeps busy high while the
// header is read back, judged and any reply written into the store, one byte per
// cycle through the store port. The result beat appears in the same cycle as
// busy falls. Result beats cannot be held off by the receiver.
`timescale 1ns / 1ps

module arp_icmp_echo_responder #(
  parameter int MAX_FRAME = arpe_pkg::MAX_FRAME_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [7:0]                    in_rx_byte,
  input  logic                          in_rx_last,
  output logic                          out_strobe,
  output logic [7:0]                    out_tx_byte,
  output logic                          out_tx_valid,
  output logic                          out_tx_last,
  output logic [1:0]                    out_verdict,
  output logic [8:0]                    out_reply_length,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [arpe_pkg::CFG_AW-1:0]   paddr,
  input  logic [arpe_pkg::CFG_DW-1:0]   pwdata,
  output logic [arpe_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  logic [31:0]    own_ip_r;
  logic [47:0]    station_mac_r;
  arpe_pkg::cmd_t cmd;
  arpe_pkg::sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r      <= '0;
      station_mac_r <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[arpe_pkg::CFG_SEL_BIT] == arpe_pkg::CFG_REG_OWN_IP) begin
        own_ip_r <= pwdata[31:0];
      end else begin
        station_mac_r <= pwdata[47:0];
      end
    end
  end

  always_comb begin
    if (paddr[arpe_pkg::CFG_SEL_BIT] == arpe_pkg::CFG_REG_MAC) begin
      prdata = {16'd0, station_mac_r};
    end else begin
      prdata = {32'd0, own_ip_r};
    end
  end

  arpe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_op      (in_op),
    .in_rx_last (in_rx_last),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  arpe_dp #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_rx_byte       (in_rx_byte),
    .in_rx_last       (in_rx_last),
    .own_ip           (own_ip_r),
    .station_mac      (station_mac_r),
    .out_strobe       (out_strobe),
    .out_tx_byte      (out_tx_byte),
    .out_tx_valid     (out_tx_valid),
    .out_tx_last      (out_tx_last),
    .out_verdict      (out_verdict),
    .out_reply_length (out_reply_length)
  );

endmodule

@@ src/arpe_checker.sv @@
// ----------------------------------------------------------------------------
// arpe_checker
// port-level checks of the responder, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arpe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic       out_tx_valid,
  input logic       out_tx_last,
  input logic [1:0] out_verdict,
  input logic [8:0] out_reply_length
);

  `ARPE_ASSERT_NXT(a_beat_has_cause, clk, rst_n, !(start || busy), !out_strobe)
  `ARPE_ASSERT_IMP(a_last_ends_reply, clk, rst_n, out_strobe && out_tx_last, out_tx_valid && out_reply_length == 9'd0)
  `ARPE_ASSERT_IMP(a_tx_no_verdict, clk, rst_n, out_strobe && out_tx_valid, out_verdict == arpe_pkg::VERDICT_NONE)
  `ARPE_ASSERT_IMP(a_arp_len, clk, rst_n, out_strobe && out_verdict == arpe_pkg::VERDICT_ARP, out_reply_length == 9'(arpe_pkg::HDR_LEN))

endmodule

bind arp_icmp_echo_responder arpe_checker u_arpe_checker (.*);

@@ dv/tb_arp_icmp_echo_responder.sv @@
// ----------------------------------------------------------------------------
// tb_arp_icmp_echo_responder
// self-checking bench for the arp / icmp echo responder: frames and pulls are
// fed one beat at a time, an in-bench model of the reply store predicts every
// result beat, and a monitor checks each strobed beat field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_arp_icmp_echo_responder;
  import arpe_pkg::*;

  localparam int STORE_DEPTH = MAX_FRAME_DEF;

  typedef struct {
    bit [7:0] tx_byte;
    bit       tx_valid;
    bit       tx_last;
    bit [1:0] verdict;
    bit [8:0] reply_len;
  } beat_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_op = 1'b0;
  logic [7:0]          in_rx_byte = '0;
  logic                in_rx_last = 1'b0;
  logic                out_strobe;
  logic [7:0]          out_tx_byte;
  logic                out_tx_valid;
  logic                out_tx_last;
  logic [1:0]          out_verdict;
  logic [8:0]          out_reply_length;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [CFG_DW-1:0]   pwdata = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  arp_icmp_echo_responder uut (.*);

  // reply store model
  bit [7:0]  store_mem [STORE_DEPTH];
  int        rx_cnt;
  bit [1:0]  pend_kind;
  int        pend_len;
  int        tx_pos;
  bit        rx_skip;
  bit [31:0] ip_cfg;
  bit [47:0] mac_cfg;

  beat_t     expected_q[$];
  bit [7:0]  frame_buf[$];
  int        errors;
  int        beats_sent;
  int        frames_sent;
  int        replies_sent;
  int        idle_pct;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("timeout with %0d beats outstanding", expected_q.size());
    $display("Some tests failed");
    $finish;
  end

  function automatic bit [15:0] rd16(int off);
    return {store_mem[off], store_mem[off+1]};
  endfunction

  function automatic bit [31:0] rd32(int off);
    return {rd16(off), rd16(off + 2)};
  endfunction

  function automatic verdict_t judge_frame(int n);
    bit [7:0]  hdr [HDR_LEN];
    bit [7:0]  tmp;
    int        tot;
    int        len;
    bit [31:0] sum;
    bit [15:0] csum;
    if (n > STORE_DEPTH || n < HDR_LEN) return VERDICT_DROP;
    if (rd16(12) == ETH_TYPE_ARP && rd32(38) == ip_cfg) begin
      for (int i = 0; i < 6; i++) begin
        hdr[i]      = store_mem[6 + i];
        hdr[6 + i]  = mac_cfg[47 - 8*i -: 8];
        hdr[22 + i] = mac_cfg[47 - 8*i -: 8];
        hdr[32 + i] = store_mem[22 + i];
      end
      {hdr[12], hdr[13]} = ETH_TYPE_ARP;
      {hdr[14], hdr[15]} = ARP_HTYPE_ETH;
      {hdr[16], hdr[17]} = ETH_TYPE_IPV4;
      hdr[18] = ARP_HLEN;
      hdr[19] = ARP_PLEN;
      {hdr[20], hdr[21]} = ARP_OP_REPLY;
      for (int i = 0; i < 4; i++) begin
        hdr[28 + i] = store_mem[38 + i];
        hdr[38 + i] = store_mem[28 + i];
      end
      for (int i = 0; i < HDR_LEN; i++) store_mem[i] = hdr[i];
      pend_len = HDR_LEN;
      return VERDICT_ARP;
    end
    if (rd16(12) == ETH_TYPE_IPV4 && rd32(30) == ip_cfg &&
        store_mem[23] == IP_PROTO_ICMP && store_mem[ICMP_OFF] == ICMP_ECHO_REQ) begin
      tot = rd16(16);
      len = tot + ETH_HDR_LEN;
      if (tot < MIN_TOT || len > n) return VERDICT_DROP;
      store_mem[ICMP_OFF] = ICMP_ECHO_REP;
      store_mem[ICMP_CSUM_OFF] = 0;
      store_mem[ICMP_CSUM_OFF + 1] = 0;
      sum = 0;
      for (int i = ICMP_OFF; i + 1 < len; i += 2) sum += rd16(i);
      if ((len - ICMP_OFF) % 2) sum += {16'h0, store_mem[len-1], 8'h0};
      sum = sum[15:0] + (sum >> 16);
      sum = sum + (sum >> 16);
      csum = ~sum[15:0] & CSUM_MASK;
      {store_mem[ICMP_CSUM_OFF], store_mem[ICMP_CSUM_OFF + 1]} = csum;
      for (int i = 0; i < 4; i++) begin
        tmp = store_mem[26 + i];
        store_mem[26 + i] = store_mem[30 + i];
        store_mem[30 + i] = tmp;
      end
      for (int i = 0; i < 6; i++) begin
        store_mem[i] = store_mem[6 + i];
        store_mem[6 + i] = mac_cfg[47 - 8*i -: 8];
      end
      pend_len = len;
      return VERDICT_ICMP;
    end
    return VERDICT_NONE;
  endfunction

  function automatic void predict_beat(bit op, bit [7:0] rxb, bit last);
    beat_t    e;
    verdict_t v;
    e = '{default: 0};
    if (op) begin
      if (pend_kind != 0 && tx_pos < pend_len && tx_pos < STORE_DEPTH) begin
        e.tx_byte = store_mem[tx_pos];
        e.tx_valid = 1'b1;
        tx_pos++;
        if (tx_pos >= pend_len) begin
          e.tx_last = 1'b1;
          pend_kind = 0;
          pend_len = 0;
          tx_pos = 0;
          replies_sent++;
        end
      end
    end else begin
      if (pend_kind != 0) rx_skip = 1'b1;
      if (!rx_skip && rx_cnt < STORE_DEPTH) store_mem[rx_cnt] = rxb;
      if (rx_cnt <= STORE_DEPTH) rx_cnt++;
      if (last) begin
        if (!rx_skip) begin
          v = judge_frame(rx_cnt);
          e.verdict = v;
          if (v == VERDICT_ARP || v == VERDICT_ICMP) begin
            pend_kind = v;
            tx_pos = 0;
          end
        end
        rx_cnt = 0;
        rx_skip = 1'b0;
        frames_sent++;
      end
    end
    e.reply_len = (pend_kind != 0) ? pend_len[8:0] : 9'd0;
    expected_q.push_back(e);
  endfunction

  function automatic void check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t mismatch %s expected %0h actual %0h", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_strobe) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected beat expected none actual byte %0h", $time, out_tx_byte);
        errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("tx_byte", e.tx_byte, out_tx_byte);
        check_field("tx_valid", e.tx_valid, out_tx_valid);
        check_field("tx_last", e.tx_last, out_tx_last);
        check_field("verdict", e.verdict, out_verdict);
        check_field("reply_length", e.reply_len, out_reply_length);
      end
    end
  end

  task automatic send_beat(bit op, bit [7:0] rxb, bit last);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_rx_byte <= rxb;
    in_rx_last <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_beat(op, rxb, last);
    beats_sent++;
  endtask

  task automatic send_pull();
    send_beat(1'b1, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_beat(1'b0, frame_buf[i], i == frame_buf.size() - 1);
  endtask

  task automatic pull_reply(int extra);
    repeat (pend_len - tx_pos + extra) send_pull();
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic cfg_write(int idx, bit [63:0] val);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= CFG_AW'(idx * 8);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == CFG_REG_OWN_IP) ip_cfg = val[31:0];
    else mac_cfg = val[47:0];
  endtask

  task automatic fill_random(int len);
    frame_buf = {};
    repeat (len) frame_buf.push_back(8'($urandom));
  endtask

  task automatic build_arp(int len, bit hit);
    fill_random(len);
    {frame_buf[12], frame_buf[13]} = ETH_TYPE_ARP;
    if (hit) {frame_buf[38], frame_buf[39], frame_buf[40], frame_buf[41]} = ip_cfg;
  endtask

  task automatic build_icmp(int len, int tot, bit hit);
    fill_random(len);
    {frame_buf[12], frame_buf[13]} = ETH_TYPE_IPV4;
    {frame_buf[16], frame_buf[17]} = tot[15:0];
    frame_buf[23] = IP_PROTO_ICMP;
    frame_buf[ICMP_OFF] = ICMP_ECHO_REQ;
    if (hit) {frame_buf[30], frame_buf[31], frame_buf[32], frame_buf[33]} = ip_cfg;
  endtask

  task automatic test_arp();
    build_arp(HDR_LEN, 1);
    send_frame();
    pull_reply(2);
    build_arp(48, 1);
    send_frame();
    pull_reply(0);
    build_arp(HDR_LEN, 0);
    send_frame();
  endtask

  task automatic test_icmp();
    build_icmp(47, 33, 1);
    send_frame();
    pull_reply(1);
    build_icmp(STORE_DEPTH, STORE_DEPTH - ETH_HDR_LEN, 1);
    send_frame();
    pull_reply(0);
    build_icmp(HDR_LEN, MIN_TOT, 1);
    send_frame();
    pull_reply(0);
  endtask

  task automatic test_special();
    build_icmp(HDR_LEN, MIN_TOT - 1, 1);
    send_frame();
    build_icmp(HDR_LEN, MIN_TOT + 1, 1);
    send_frame();
    build_icmp(HDR_LEN, MIN_TOT, 0);
    send_frame();
    fill_random(10);
    send_frame();
    fill_random(1);
    send_frame();
    fill_random(HDR_LEN - 1);
    send_frame();
    fill_random(STORE_DEPTH + 1);
    send_frame();
    build_arp(HDR_LEN, 1);
    send_frame();
    // partial read then a frame while the reply is still held
    repeat (5) send_pull();
    build_arp(HDR_LEN, 1);
    send_frame();
    pull_reply(3);
    drain();
    repeat (4) send_beat(1'b1, 8'hff, 1'b1);
  endtask

  task automatic run_random(int n_beats);
    int r;
    int len;
    int tot;
    int stop_at;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 35) begin
        build_arp($urandom_range(HDR_LEN, 64), $urandom_range(99) < 85);
      end else if (r < 75) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(HDR_LEN, STORE_DEPTH)
                                       : $urandom_range(HDR_LEN, 100);
        tot = len - ETH_HDR_LEN;
        r = $urandom_range(99);
        if (r < 15) tot = $urandom_range(MIN_TOT, tot);
        else if (r < 25) tot = $urandom_range(1) ? $urandom_range(0, MIN_TOT - 1)
                                                 : $urandom_range(tot + 1, 16'hffff);
        build_icmp(len, tot, 1);
        r = $urandom_range(99);
        if (r < 4) frame_buf[23] = 8'($urandom);
        else if (r < 8) frame_buf[ICMP_OFF] = 8'($urandom);
        else if (r < 12) frame_buf[30 + $urandom_range(3)] ^= 8'h01 << $urandom_range(7);
      end else if (r < 92) begin
        fill_random($urandom_range(1, 80));
      end else if (r < 94) begin
        fill_random($urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 12));
      end else begin
        frame_buf = {};
        repeat ($urandom_range(1, 10)) send_pull();
      end
      send_frame();
      if (pend_kind != 0) begin
        r = $urandom_range(99);
        if (r < 80) pull_reply($urandom_range(0, 2));
        else if (r < 90) repeat ($urandom_range(1, 20)) send_pull();
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_write(CFG_REG_OWN_IP, 64'hc0a8_0107);
    cfg_write(CFG_REG_MAC, 64'h0012_3456_789a);
    test_arp();
    test_icmp();
    test_special();

    cfg_write(CFG_REG_OWN_IP, 64'hffff_ffff);
    cfg_write(CFG_REG_MAC, 64'h0);
    idle_pct = 0;
    run_random(20);

    cfg_write(CFG_REG_OWN_IP, 64'h0);
    cfg_write(CFG_REG_MAC, 64'hffff_ffff_ffff);
    idle_pct = 69;
    run_random(20);

    cfg_write(CFG_REG_OWN_IP, {32'h0, $urandom});
    cfg_write(CFG_REG_MAC, {16'h0, 16'($urandom), $urandom});
    idle_pct = 22;
    run_random(20);

    idle_pct = 0;
    run_random(20);

    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d beats, %0d frames and %0d complete replies", beats_sent,
             frames_sent, replies_sent);
    $display("under four address settings and sender gaps from none to most cycles");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
